// ===== sv/rcfw_pkg.sv =====
// Shared types and constants of the receiver frame decoder and wheel speed mixer.
`default_nettype none

package rcfw_pkg;

  // Frame geometry
  localparam int unsigned NumChannels = 14;
  localparam int unsigned FrameLen    = 2 + 2 * NumChannels;
  localparam int unsigned PosW        = $clog2(FrameLen + 1);
  localparam int unsigned ChIdxW      = $clog2(NumChannels);

  // Header bytes
  localparam logic [7:0] HeaderB0 = 8'h20;
  localparam logic [7:0] HeaderB1 = 8'h40;

  // Widths of the mixer datapath
  localparam int unsigned DiffW = 17;
  localparam int unsigned ProdW = 26;
  localparam int unsigned SumW  = 27;
  localparam int unsigned RefW  = 32;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpinChannel     = 3'd0,
    CfgThrottleChannel = 3'd1,
    CfgSpinCenter      = 3'd2,
    CfgSpinGain        = 3'd3,
    CfgThrottleOffset  = 3'd4,
    CfgThrottleGain    = 3'd5,
    CfgDeadZone        = 3'd6
  } cfg_idx_e;

  // Register file contents
  typedef struct packed {
    logic [3:0]  spin_channel;
    logic [3:0]  throttle_channel;
    logic [15:0] spin_center;
    logic [7:0]  spin_gain;
    logic [15:0] throttle_offset;
    logic [7:0]  throttle_gain;
    logic [15:0] dead_zone;
  } cfg_t;

  // One received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rcfw_in_t;

  // One mixer result
  typedef struct packed {
    logic                   frame_ok;
    logic signed [RefW-1:0] ref_left;
    logic signed [RefW-1:0] ref_right;
    logic                   reverse_left;
    logic                   reverse_right;
  } rcfw_out_t;

  // Channel pair read from the store for one completed frame
  typedef struct packed {
    logic        frame_ok;
    logic [15:0] spin_raw;
    logic [15:0] throttle_raw;
  } rcfw_chan_t;

endpackage

`default_nettype wire

// ===== sv/rcfw_cfg_regs.sv =====
// Configuration register file of the wheel speed mixer.
`default_nettype none

module rcfw_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rcfw_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [rcfw_pkg::CfgDataW-1:0]    cfg_data_i,
  output rcfw_pkg::cfg_t                        cfg_o
);
  import rcfw_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register write decoder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spin_channel     <= 4'd0;
      cfg_q.throttle_channel <= 4'd2;
      cfg_q.spin_center      <= 16'd1500;
      cfg_q.spin_gain        <= 8'd16;
      cfg_q.throttle_offset  <= 16'd1000;
      cfg_q.throttle_gain    <= 8'd51;
      cfg_q.dead_zone        <= 16'd320;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSpinChannel:     cfg_q.spin_channel     <= cfg_data_i[3:0];
        CfgThrottleChannel: cfg_q.throttle_channel <= cfg_data_i[3:0];
        CfgSpinCenter:      cfg_q.spin_center      <= cfg_data_i;
        CfgSpinGain:        cfg_q.spin_gain        <= cfg_data_i[7:0];
        CfgThrottleOffset:  cfg_q.throttle_offset  <= cfg_data_i;
        CfgThrottleGain:    cfg_q.throttle_gain    <= cfg_data_i[7:0];
        CfgDeadZone:        cfg_q.dead_zone        <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/rcfw_frame_parser.sv =====
// Frame byte parser with header check, channel store and channel read stage.
`default_nettype none

module rcfw_frame_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire rcfw_pkg::rcfw_in_t   in_req_i,
  input  wire rcfw_pkg::cfg_t       cfg_i,
  output logic                      chan_valid_o,
  input  wire logic                 chan_ready_i,
  output rcfw_pkg::rcfw_chan_t      chan_o
);
  import rcfw_pkg::*;

  logic [PosW-1:0]   pos_q, pos_eff;
  logic              header_q;
  logic [7:0]        low_hold_q;
  logic              done_q;
  logic              chan_v_q;
  rcfw_chan_t        chan_q;
  logic [15:0]       store_q [NumChannels];
  logic [NumChannels-1:0] vld_q;

  logic              accept, active, last_byte, adv_rd;
  logic              wr_en;
  logic [PosW-1:0]   ch_off;
  logic [ChIdxW-1:0] wr_idx, spin_idx, thr_idx;

  // Position of the current byte; a start flag restarts the frame.
  assign accept    = in_valid_i && in_ready_o;
  assign pos_eff   = in_req_i.frame_start ? '0 : pos_q;
  assign active    = pos_eff < PosW'(FrameLen);
  assign last_byte = accept && active && (pos_eff == PosW'(FrameLen - 1));
  assign ch_off    = (pos_eff - PosW'(3)) >> 1;
  assign wr_idx    = ch_off[ChIdxW-1:0];
  assign wr_en     = accept && active && (pos_eff >= PosW'(3)) && pos_eff[0] && header_q;

  // A finished frame waits here until the read stage is free; bytes are held off meanwhile.
  assign adv_rd     = done_q && (!chan_v_q || chan_ready_i);
  assign in_ready_o = !done_q || adv_rd;

  // Channel indices beyond the store fall back to the last channel.
  assign spin_idx = ({1'b0, cfg_i.spin_channel} >= 5'(NumChannels)) ?
                    ChIdxW'(NumChannels - 1) : cfg_i.spin_channel[ChIdxW-1:0];
  assign thr_idx  = ({1'b0, cfg_i.throttle_channel} >= 5'(NumChannels)) ?
                    ChIdxW'(NumChannels - 1) : cfg_i.throttle_channel[ChIdxW-1:0];

  // Frame control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosW'(FrameLen);
      header_q <= 1'b0;
      done_q   <= 1'b0;
      chan_v_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (accept && active) begin
        pos_q <= pos_eff + PosW'(1);
        if (pos_eff == '0) begin
          header_q <= (in_req_i.rx_byte == HeaderB0);
        end else if (pos_eff == PosW'(1)) begin
          header_q <= header_q && (in_req_i.rx_byte == HeaderB1);
        end
      end else if (accept) begin
        pos_q <= pos_eff;
      end
      if (wr_en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      done_q <= last_byte || (done_q && !adv_rd);
      if (adv_rd) begin
        chan_v_q <= 1'b1;
      end else if (chan_ready_i) begin
        chan_v_q <= 1'b0;
      end
    end
  end

  // Low byte hold and channel store writes
  always_ff @(posedge clk_i) begin
    if (accept && active && (pos_eff >= PosW'(2)) && !pos_eff[0]) begin
      low_hold_q <= in_req_i.rx_byte;
    end
    if (wr_en) begin
      store_q[wr_idx] <= {in_req_i.rx_byte, low_hold_q};
    end
  end

  // Registered read of the two selected channels; unwritten entries read as zero.
  always_ff @(posedge clk_i) begin
    if (adv_rd) begin
      chan_q.frame_ok     <= header_q;
      chan_q.spin_raw     <= vld_q[spin_idx] ? store_q[spin_idx] : 16'd0;
      chan_q.throttle_raw <= vld_q[thr_idx] ? store_q[thr_idx] : 16'd0;
    end
  end

  assign chan_valid_o = chan_v_q;
  assign chan_o       = chan_q;

  // Bytes are refused only while a finished frame is waiting for the read stage.
  a_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> done_q)
    else $error("input refused without a pending frame");

  // A pending frame is never dropped before it reaches the read stage.
  a_done_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !adv_rd |=> done_q)
    else $error("pending frame lost");

  // The byte position never runs past the idle value.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(FrameLen))
    else $error("byte position out of range");

endmodule

`default_nettype wire

// ===== sv/rcfw_mixer.sv =====
// Differential drive mixer: product stage and result register with dead zone.
`default_nettype none

module rcfw_mixer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 chan_valid_i,
  output logic                      chan_ready_o,
  input  wire rcfw_pkg::rcfw_chan_t chan_i,
  input  wire rcfw_pkg::cfg_t       cfg_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rcfw_pkg::rcfw_out_t       out_rsp_o
);
  import rcfw_pkg::*;

  logic                    prod_v_q, res_v_q;
  logic                    prod_ok_q;
  logic signed [ProdW-1:0] spin_prod_q, thr_prod_q;
  rcfw_out_t               res_q;

  logic                    prod_ready, res_ready, prod_adv, res_adv;
  logic signed [DiffW-1:0] spin_diff, thr_diff;
  logic signed [ProdW-1:0] spin_prod, thr_prod;
  logic signed [SumW-1:0]  left_sum, right_sum, dz;
  logic                    in_dz, zero_out;
  logic signed [RefW-1:0]  left_ref, right_ref;

  // Stage handshakes
  assign res_ready    = !res_v_q || out_ready_i;
  assign prod_ready   = !prod_v_q || res_ready;
  assign chan_ready_o = prod_ready;
  assign prod_adv     = chan_valid_i && prod_ready;
  assign res_adv      = prod_v_q && res_ready;

  // Centred channel values times gain; results fit well inside 32 bits.
  assign spin_diff = signed'({1'b0, chan_i.spin_raw} - {1'b0, cfg_i.spin_center});
  assign thr_diff  = signed'({1'b0, chan_i.throttle_raw} - {1'b0, cfg_i.throttle_offset});
  assign spin_prod = spin_diff * signed'({1'b0, cfg_i.spin_gain});
  assign thr_prod  = thr_diff * signed'({1'b0, cfg_i.throttle_gain});

  // Wheel sums and dead zone test on the left wheel.
  assign left_sum  = {thr_prod_q[ProdW-1], thr_prod_q} + {spin_prod_q[ProdW-1], spin_prod_q};
  assign right_sum = {thr_prod_q[ProdW-1], thr_prod_q} - {spin_prod_q[ProdW-1], spin_prod_q};
  assign dz        = signed'({{(SumW - 16){1'b0}}, cfg_i.dead_zone});
  assign in_dz     = (left_sum <= dz) && (left_sum >= -dz);
  assign zero_out  = !prod_ok_q || in_dz;
  assign left_ref  = zero_out ? '0 : {{(RefW - SumW){left_sum[SumW-1]}}, left_sum};
  assign right_ref = zero_out ? '0 : {{(RefW - SumW){right_sum[SumW-1]}}, right_sum};

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_v_q <= chan_valid_i;
      end
      if (res_ready) begin
        res_v_q <= prod_v_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (prod_adv) begin
      prod_ok_q   <= chan_i.frame_ok;
      spin_prod_q <= spin_prod;
      thr_prod_q  <= thr_prod;
    end
    if (res_adv) begin
      res_q.frame_ok      <= prod_ok_q;
      res_q.ref_left      <= left_ref;
      res_q.ref_right     <= right_ref;
      res_q.reverse_left  <= left_ref[RefW-1];
      res_q.reverse_right <= right_ref[RefW-1];
    end
  end

  assign out_valid_o = res_v_q;
  assign out_rsp_o   = res_q;

  // A frame with a bad header always gives zero references.
  a_bad_header_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !res_q.frame_ok |-> res_q.ref_left == '0 && res_q.ref_right == '0)
    else $error("bad header frame with non-zero references");

  // A zero left reference lies in the dead zone, so the right one is zeroed too.
  a_left_zero_right_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && res_q.ref_left == '0 |-> res_q.ref_right == '0)
    else $error("right reference not zeroed with left");

  // A waiting result stays valid and keeps its value until it is taken.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !out_ready_i |=> res_v_q && $stable(res_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== sv/rc_frame_to_wheel_speed_mixer.sv =====
// Top level of the receiver frame decoder and differential drive wheel speed mixer.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o    rcfw_in_t: rx_byte, frame_start
//   out      output     out_valid_o / out_ready_i  rcfw_out_t: frame_ok, refs, reverse flags
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte is taken per cycle unless bytes are refused as below. A frame's last byte passes
// through the channel read, product stage and result register to give its result.
// Reset clears the frame position to idle, the header flag and the store valid bits.
// A byte is refused only while a finished frame waits for the channel read stage,
// which happens when the output has been stalled for more than three results.
`default_nettype none

module rc_frame_to_wheel_speed_mixer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rcfw_pkg::rcfw_in_t            in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rcfw_pkg::rcfw_out_t                out_rsp_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rcfw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rcfw_pkg::CfgDataW-1:0] cfg_data_i
);
  import rcfw_pkg::*;

  cfg_t       cfg;
  rcfw_chan_t chan;
  logic       chan_valid, chan_ready;

  // Configuration registers
  rcfw_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Frame parsing and channel store
  rcfw_frame_parser u_frame_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .cfg_i        (cfg),
    .chan_valid_o (chan_valid),
    .chan_ready_i (chan_ready),
    .chan_o       (chan)
  );

  // Wheel speed mixing
  rcfw_mixer u_mixer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chan_valid_i (chan_valid),
    .chan_ready_o (chan_ready),
    .chan_i       (chan),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

`default_nettype wire
